[rtl/cti_pkg.sv]
// ----------------------------------------------------------------------------
// cti_pkg
// Shared types and constants for the curve table interpolator.
// ----------------------------------------------------------------------------
package cti_pkg;

   localparam int DATA_W    = 16;
   localparam int DIV_STEPS = 16;

   localparam logic [1:0] OP_WRITE_AXIS  = 2'd0;
   localparam logic [1:0] OP_WRITE_VALUE = 2'd1;
   localparam logic [1:0] OP_LOOKUP      = 2'd2;
   localparam logic [1:0] OP_RESERVED    = 2'd3;

   localparam logic [4:0] POINTS_RESET = 5'd16;

   typedef struct packed {
      logic [1:0]               operation;
      logic [3:0]               point_index;
      logic signed [DATA_W-1:0] data_or_x;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] y_value;
      logic [3:0]               bin_upper;
   } rsp_type;

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_TOP  = 8'b0000_0010,
      S_HI   = 8'b0000_0100,
      S_LO   = 8'b0000_1000,
      S_EVAL = 8'b0001_0000,
      S_MUL  = 8'b0010_0000,
      S_DIV  = 8'b0100_0000,
      S_DONE = 8'b1000_0000
   } state_type;

endpackage

[rtl/cti_curve_store.sv]
// ----------------------------------------------------------------------------
// cti_curve_store
// Axis and value point memories, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module cti_curve_store #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic                              wr_sel_value,
   input  logic [ADDR_W-1:0]                 wr_addr,
   input  logic signed [cti_pkg::DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]                 rd_addr,
   output logic signed [cti_pkg::DATA_W-1:0] axis_rd,
   output logic signed [cti_pkg::DATA_W-1:0] value_rd
);
   import cti_pkg::*;

   logic signed [DATA_W-1:0] axis_mem [DEPTH];
   logic signed [DATA_W-1:0] value_mem [DEPTH];
   logic signed [DATA_W-1:0] axis_rd_ff;
   logic signed [DATA_W-1:0] value_rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en && !wr_sel_value) begin
         axis_mem[wr_addr] <= wr_data;
      end
      if (wr_en && wr_sel_value) begin
         value_mem[wr_addr] <= wr_data;
      end
      axis_rd_ff  <= axis_mem[rd_addr];
      value_rd_ff <= value_mem[rd_addr];
   end

   assign axis_rd  = axis_rd_ff;
   assign value_rd = value_rd_ff;

endmodule

[rtl/cti_divider.sv]
// ----------------------------------------------------------------------------
// cti_divider
// Restoring serial divider, one quotient bit per cycle, 16-bit quotient.
// ----------------------------------------------------------------------------
module cti_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [15:0] quotient
);
   import cti_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] dvd_ff, dvd_in;
   logic [15:0] den_ff, den_in;
   logic [16:0] shifted;
   logic [16:0] trial;
   logic        ge;

   always_comb begin
      shifted = {rem_ff, dvd_ff[15]};
      trial   = shifted - {1'b0, den_ff};
      ge      = (shifted >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = dividend[31:16];
         dvd_in  = dividend[15:0];
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? trial[15:0] : shifted[15:0];
         dvd_in = {dvd_ff[14:0], ge};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

[rtl/curve_table_interpolator.sv]
// ----------------------------------------------------------------------------
// curve_table_interpolator
// Piecewise linear curve lookup with bin search and serial division.
// Table writes are taken while idle. A lookup reads the top point, then
// the remembered bin, and after a miss there checks bins one by one down
// from the top (up to points-1); unless exact or clipped, it then does a
// multiply and 16-step serial divide, and waits while the last result stalls.
// One item at a time; the bin search and the divider set the rate.
// Synchronous reset: idle, remembered bin 1, points in use 16; table undefined.
// ----------------------------------------------------------------------------
module curve_table_interpolator #(
   parameter int MAX_POINTS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cti_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cti_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [4:0]       csr_data
);
   import cti_pkg::*;

   localparam int PTR_W = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

   state_type state_ff, state_in;

   logic [4:0]               points_ff, points_in;
   logic [3:0]               last_bin_ff, last_bin_in;
   logic [PTR_W-1:0]         bin_ff, bin_in;
   logic                     searching_ff, searching_in;
   logic                     inbin_ff, inbin_in;
   logic signed [DATA_W-1:0] x_ff, x_in;
   logic signed [DATA_W-1:0] xu_ff, xu_in;
   logic signed [DATA_W-1:0] yu_ff, yu_in;
   logic signed [DATA_W-1:0] xl_ff, xl_in;
   logic signed [DATA_W-1:0] yl_ff, yl_in;
   logic signed [DATA_W-1:0] top_axis_ff, top_axis_in;
   logic signed [DATA_W-1:0] top_value_ff, top_value_in;
   logic signed [DATA_W-1:0] y_ff, y_in;
   logic [31:0]              prod_ff, prod_in;
   logic                     neg_ff, neg_in;
   logic [15:0]              den_ff, den_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic                     req_accept;
   logic                     wr_en;
   logic [PTR_W-1:0]         rd_addr;
   logic signed [DATA_W-1:0] axis_rd;
   logic signed [DATA_W-1:0] value_rd;
   logic [PTR_W-1:0]         top;
   logic [PTR_W-1:0]         bin_start;
   logic                     lo_inbin;
   logic [16:0]              dx17;
   logic [16:0]              dy17;
   logic [16:0]              ndy17;
   logic [16:0]              dxu17;
   logic                     div_start;
   logic                     div_done;
   logic [15:0]              div_quo;
   int                       npts;
   int                       bsel;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign wr_en      = req_accept
                       && (req_data.operation == OP_WRITE_AXIS
                           || req_data.operation == OP_WRITE_VALUE)
                       && (int'(req_data.point_index) < MAX_POINTS);

   always_comb begin
      npts = int'(points_ff);
      if (npts < 2) npts = 2;
      if (npts > MAX_POINTS) npts = MAX_POINTS;
      top  = PTR_W'(npts - 1);
      bsel = int'(last_bin_ff);
      if (bsel > npts - 1) bsel = npts - 1;
      if (bsel < 1) bsel = 1;
      bin_start = PTR_W'(bsel);
   end

   cti_curve_store #(
      .DEPTH  (MAX_POINTS),
      .ADDR_W (PTR_W)
   ) u_store (
      .clock        (clock),
      .wr_en        (wr_en),
      .wr_sel_value (req_data.operation == OP_WRITE_VALUE),
      .wr_addr      (PTR_W'(req_data.point_index)),
      .wr_data      (req_data.data_or_x),
      .rd_addr      (rd_addr),
      .axis_rd      (axis_rd),
      .value_rd     (value_rd)
   );

   cti_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign lo_inbin  = (x_ff <= xu_ff) && (x_ff > axis_rd);
   assign div_start = (state_ff == S_MUL);

   always_comb begin
      dx17  = {x_ff[15], x_ff} - {xl_ff[15], xl_ff};
      dy17  = {yu_ff[15], yu_ff} - {yl_ff[15], yl_ff};
      ndy17 = 17'd0 - dy17;
      dxu17 = {xu_ff[15], xu_ff} - {xl_ff[15], xl_ff};
   end

   always_comb begin
      state_in     = state_ff;
      points_in    = points_ff;
      last_bin_in  = last_bin_ff;
      bin_in       = bin_ff;
      searching_in = searching_ff;
      inbin_in     = inbin_ff;
      x_in         = x_ff;
      xu_in        = xu_ff;
      yu_in        = yu_ff;
      xl_in        = xl_ff;
      yl_in        = yl_ff;
      top_axis_in  = top_axis_ff;
      top_value_in = top_value_ff;
      y_in         = y_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      den_in       = den_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = top;

      if (csr_valid && csr_ready) begin
         points_in = csr_data;
      end

      case (state_ff)
         S_IDLE: begin
            rd_addr = top;
            if (req_accept) begin
               case (req_data.operation)
                  OP_LOOKUP: begin
                     x_in         = req_data.data_or_x;
                     searching_in = 1'b0;
                     state_in     = S_TOP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_TOP: begin
            top_axis_in  = axis_rd;
            top_value_in = value_rd;
            bin_in       = bin_start;
            rd_addr      = bin_start;
            state_in     = S_HI;
         end
         S_HI: begin
            xu_in    = axis_rd;
            yu_in    = value_rd;
            rd_addr  = bin_ff - PTR_W'(1);
            state_in = S_LO;
         end
         S_LO: begin
            if (lo_inbin || (searching_ff && bin_ff == PTR_W'(1))) begin
               xl_in    = axis_rd;
               yl_in    = value_rd;
               inbin_in = lo_inbin;
               rd_addr  = '0;
               state_in = S_EVAL;
            end else if (!searching_ff) begin
               searching_in = 1'b1;
               bin_in       = top;
               xu_in        = top_axis_ff;
               yu_in        = top_value_ff;
               rd_addr      = top - PTR_W'(1);
            end else begin
               bin_in  = bin_ff - PTR_W'(1);
               xu_in   = axis_rd;
               yu_in   = value_rd;
               rd_addr = bin_ff - PTR_W'(2);
            end
         end
         S_EVAL: begin
            if (x_ff == xu_ff) begin
               y_in     = yu_ff;
               state_in = S_DONE;
            end else if (inbin_ff) begin
               neg_in   = dy17[16];
               prod_in  = {16'd0, dx17[15:0]}
                          * {16'd0, (dy17[16] ? ndy17[15:0] : dy17[15:0])};
               den_in   = dxu17[15:0];
               state_in = S_MUL;
            end else if (x_ff >= top_axis_ff) begin
               y_in     = top_value_ff;
               bin_in   = top;
               state_in = S_DONE;
            end else begin
               y_in     = value_rd;
               bin_in   = PTR_W'(1);
               state_in = S_DONE;
            end
         end
         S_MUL: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               y_in     = neg_ff ? (yl_ff - signed'(div_quo)) : (yl_ff + signed'(div_quo));
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.y_value   = y_ff;
               rsp_data_in.bin_upper = 4'(bin_ff);
               last_bin_in           = 4'(bin_ff);
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         points_ff    <= POINTS_RESET;
         last_bin_ff  <= 4'd1;
         rsp_valid_ff <= 1'b0;
         searching_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         points_ff    <= points_in;
         last_bin_ff  <= last_bin_in;
         rsp_valid_ff <= rsp_valid_in;
         searching_ff <= searching_in;
      end
      bin_ff       <= bin_in;
      inbin_ff     <= inbin_in;
      x_ff         <= x_in;
      xu_ff        <= xu_in;
      yu_ff        <= yu_in;
      xl_ff        <= xl_in;
      yl_ff        <= yl_in;
      top_axis_ff  <= top_axis_in;
      top_value_ff <= top_value_in;
      y_ff         <= y_in;
      prod_ff      <= prod_in;
      neg_ff       <= neg_in;
      den_ff       <= den_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_lookup_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_data.operation == OP_LOOKUP |=> state_ff == S_TOP)
      else $error("lookup item did not start the sequencer");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside the done state");

   a_bin_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LO |-> (bin_ff != '0) && (bin_ff <= top))
      else $error("search bin out of range");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider finished outside the divide state");

endmodule
